// ----- hdl/lobm_pkg.sv -----
// shared types, codes and sizes for the limit order book matcher
package lobm_pkg;

  localparam int MAX_ORDERS = 32;
  localparam int IDX_W      = $clog2(MAX_ORDERS);

  // request modes
  localparam logic [1:0] MODE_LIMIT  = 2'd0;
  localparam logic [1:0] MODE_MARKET = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;
  localparam logic [1:0] MODE_MODIFY = 2'd3;

  // final status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADQTY  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_MKTCXL  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // result kinds
  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        req_id;
    logic               side;
    logic signed [31:0] px_limit;
    logic [31:0]        quantity;
  } lobm_in_t;

  typedef struct packed {
    logic               result_kind;
    logic [63:0]        taker_id;
    logic [63:0]        maker_id;
    logic signed [31:0] trade_price;
    logic [31:0]        fill_quantity;
    logic [2:0]         status;
    logic [31:0]        filled_total;
    logic [31:0]        qty_left;
    logic               last;
  } lobm_out_t;

  // search record that travels down the row of cells
  typedef struct packed {
    logic             active;
    logic             side;
    logic             by_id;
    logic [63:0]      id;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [31:0]      price;
    logic [31:0]      age;
    logic [63:0]      eid;
    logic [31:0]      qty;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } lobm_query_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_QTY,
    WR_LOAD
  } lobm_wop_t;

  // book update broadcast to all cells
  typedef struct packed {
    lobm_wop_t        op;
    logic [IDX_W-1:0] idx;
    logic             side;
    logic [63:0]      id;
    logic [31:0]      price;
    logic [31:0]      qty;
    logic [31:0]      arrival;
  } lobm_wr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CXL_LAUNCH0,
    S_CXL_WAIT0,
    S_CXL_LAUNCH1,
    S_CXL_WAIT1,
    S_ADD_START,
    S_MATCH_LAUNCH,
    S_MATCH_WAIT,
    S_TRADE,
    S_FINISH,
    S_STATUS
  } lobm_state_t;

endpackage

// ----- hdl/lobm_cell.sv -----
// one book entry plus one stage of the best-order search
module lobm_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lobm_pkg::IDX_W-1:0]  cell_idx,
  input  logic [31:0]                 counter,
  input  lobm_pkg::lobm_query_t       q_in,
  input  lobm_pkg::lobm_wr_t          wr,
  output lobm_pkg::lobm_query_t       q_out
);
  import lobm_pkg::*;

  logic        valid_r;
  logic        side_r;
  logic [63:0] id_r;
  logic [31:0] price_r;
  logic [31:0] qty_r;
  logic [31:0] arrival_r;
  lobm_query_t q_r;
  lobm_query_t q_nxt;

  logic [31:0] key_own;
  logic [31:0] key_best;
  logic [31:0] age_own;
  logic        elig;
  logic        better;

  // compare own entry against the best seen so far
  always_comb begin
    key_own  = price_r ^ SIGN_FLIP;
    key_best = q_in.price ^ SIGN_FLIP;
    age_own  = counter - arrival_r;
    elig     = valid_r && (side_r == q_in.side) && (!q_in.by_id || (id_r == q_in.id));
    if (key_own != key_best) begin
      better = q_in.side ? (key_own < key_best) : (key_own > key_best);
    end else begin
      better = age_own > q_in.age;
    end
    q_nxt = q_in;
    if (q_in.active && elig && (!q_in.found || better)) begin
      q_nxt.found = 1'b1;
      q_nxt.idx   = cell_idx;
      q_nxt.price = price_r;
      q_nxt.age   = age_own;
      q_nxt.eid   = id_r;
      q_nxt.qty   = qty_r;
    end
    if (!valid_r && !q_in.free_found) begin
      q_nxt.free_found = 1'b1;
      q_nxt.free_idx   = cell_idx;
    end
  end

  // search stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.active <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  // entry valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.idx == cell_idx) begin
      if (wr.op == WR_CLEAR) begin
        valid_r <= 1'b0;
      end else if (wr.op == WR_LOAD) begin
        valid_r <= 1'b1;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (wr.idx == cell_idx) begin
      if (wr.op == WR_LOAD) begin
        side_r    <= wr.side;
        id_r      <= wr.id;
        price_r   <= wr.price;
        qty_r     <= wr.qty;
        arrival_r <= wr.arrival;
      end else if (wr.op == WR_QTY) begin
        qty_r <= wr.qty;
      end
    end
  end

  assign q_out = q_r;

endmodule

// ----- hdl/limit_order_book_matcher.sv -----
// top level of the limit order book matcher: request sequencer and cell row
// The book is a row of MAX_ORDERS cells, one resting order each. Every search
// (best opposite order, or an id to cancel) is started in a launch state and
// then sweeps the row one cell per cycle, through all MAX_ORDERS cells. A limit
// or market request goes through an add start, a search and a trade per fill, a
// last search that ends the matching if quantity is left, and the status item;
// a zero quantity goes from the add start straight to the status item. A cancel
// searches the bids for the id, then the asks when it is not among the bids. A
// modify puts this cancel search before the add. Output stalls stretch every
// trade and status step. One request is worked at a time; in_stall is high
// until the final status item has been loaded into the output register, which
// holds against out_stall.
module limit_order_book_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lobm_pkg::lobm_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lobm_pkg::lobm_out_t out_item
);
  import lobm_pkg::*;

  lobm_state_t state_r, state_nxt;
  lobm_in_t    req_r, req_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] filled_r, filled_nxt;
  logic [31:0] counter_r, counter_nxt;
  logic [2:0]  status_r, status_nxt;
  lobm_query_t res_r, res_nxt;
  lobm_out_t   out_r;
  logic        out_valid_r;

  lobm_query_t q_start;
  lobm_query_t q_chain [MAX_ORDERS+1];
  lobm_query_t q_end;
  lobm_wr_t    wr;
  logic        emit;
  lobm_out_t   emit_item;
  logic        out_free;
  logic [31:0] fill;
  logic [31:0] key_lim;
  logic [31:0] key_best;
  logic        price_fail;

  // row of cells
  assign q_chain[0] = q_start;
  for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
    lobm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .counter  (counter_r),
      .q_in     (q_chain[i]),
      .wr       (wr),
      .q_out    (q_chain[i+1])
    );
  end
  assign q_end = q_chain[MAX_ORDERS];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // helpers for matching
  always_comb begin
    fill       = (rem_r < res_r.qty) ? rem_r : res_r.qty;
    key_lim    = req_r.px_limit ^ SIGN_FLIP;
    key_best   = q_end.price ^ SIGN_FLIP;
    price_fail = req_r.side ? (key_lim > key_best) : (key_lim < key_best);
  end

  // next state and outputs
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    rem_nxt     = rem_r;
    filled_nxt  = filled_r;
    counter_nxt = counter_r;
    status_nxt  = status_r;
    res_nxt     = res_r;
    q_start     = '0;
    wr          = '0;
    wr.op       = WR_NONE;
    emit        = 1'b0;
    emit_item   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_item;
          rem_nxt    = in_item.quantity;
          filled_nxt = '0;
          if (in_item.mode == MODE_CANCEL || in_item.mode == MODE_MODIFY) begin
            state_nxt = S_CXL_LAUNCH0;
          end else begin
            state_nxt = S_ADD_START;
          end
        end
      end
      S_CXL_LAUNCH0, S_CXL_LAUNCH1: begin
        q_start.active = 1'b1;
        q_start.by_id  = 1'b1;
        q_start.id     = req_r.req_id;
        q_start.side   = (state_r == S_CXL_LAUNCH1);
        state_nxt      = (state_r == S_CXL_LAUNCH0) ? S_CXL_WAIT0 : S_CXL_WAIT1;
      end
      S_CXL_WAIT0, S_CXL_WAIT1: begin
        if (q_end.active) begin
          if (q_end.found) begin
            wr.op  = WR_CLEAR;
            wr.idx = q_end.idx;
          end
          if (!q_end.found && state_r == S_CXL_WAIT0) begin
            state_nxt = S_CXL_LAUNCH1;
          end else if (req_r.mode == MODE_CANCEL) begin
            status_nxt = q_end.found ? ST_OK : ST_UNKNOWN;
            rem_nxt    = '0;
            filled_nxt = '0;
            state_nxt  = S_STATUS;
          end else begin
            state_nxt = S_ADD_START;
          end
        end
      end
      S_ADD_START: begin
        if (req_r.quantity == '0) begin
          status_nxt = ST_BADQTY;
          rem_nxt    = '0;
          filled_nxt = '0;
          state_nxt  = S_STATUS;
        end else begin
          state_nxt = S_MATCH_LAUNCH;
        end
      end
      S_MATCH_LAUNCH: begin
        q_start.active = 1'b1;
        q_start.side   = !req_r.side;
        state_nxt      = S_MATCH_WAIT;
      end
      S_MATCH_WAIT: begin
        if (q_end.active) begin
          res_nxt = q_end;
          if (!q_end.found || (req_r.mode != MODE_MARKET && price_fail)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_TRADE;
          end
        end
      end
      S_TRADE: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_item.result_kind   = KIND_TRADE;
          emit_item.taker_id      = req_r.req_id;
          emit_item.maker_id      = res_r.eid;
          emit_item.trade_price   = res_r.price;
          emit_item.fill_quantity = fill;
          wr.idx                  = res_r.idx;
          wr.qty                  = res_r.qty - fill;
          wr.op                   = (res_r.qty == fill) ? WR_CLEAR : WR_QTY;
          rem_nxt                 = rem_r - fill;
          filled_nxt              = filled_r + fill;
          state_nxt               = (rem_r == fill) ? S_FINISH : S_MATCH_LAUNCH;
        end
      end
      S_FINISH: begin
        state_nxt = S_STATUS;
        if (rem_r == '0) begin
          status_nxt = ST_OK;
        end else if (req_r.mode == MODE_MARKET) begin
          status_nxt = ST_MKTCXL;
        end else if (res_r.free_found) begin
          wr.op       = WR_LOAD;
          wr.idx      = res_r.free_idx;
          wr.side     = req_r.side;
          wr.id       = req_r.req_id;
          wr.price    = req_r.px_limit;
          wr.qty      = rem_r;
          wr.arrival  = counter_r;
          counter_nxt = counter_r + 32'd1;
          status_nxt  = ST_OK;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_item.result_kind  = KIND_STATUS;
          emit_item.status       = status_r;
          emit_item.filled_total = filled_r;
          emit_item.qty_left     = rem_r;
          emit_item.last         = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      counter_r <= '0;
    end else begin
      state_r   <= state_nxt;
      counter_r <= counter_nxt;
    end
  end

  // request working registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    rem_r    <= rem_nxt;
    filled_r <= filled_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // a search result only arrives while the sequencer waits for one
  a_search_wait: assert property (@(posedge clk) disable iff (!rst_n)
    q_end.active |-> (state_r == S_CXL_WAIT0 || state_r == S_CXL_WAIT1 ||
                      state_r == S_MATCH_WAIT))
    else $error("search result arrived outside a wait state");

  // the book is not written while a search is being launched
  a_book_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CXL_LAUNCH0 || state_r == S_CXL_LAUNCH1 ||
     state_r == S_MATCH_LAUNCH) |-> (wr.op == WR_NONE))
    else $error("book written while a search was launched");

  // at the finish step, filled plus remaining accounts for the ordered quantity
  a_qty_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |->
      (({1'b0, filled_r} + {1'b0, rem_r}) == {1'b0, req_r.quantity}))
    else $error("filled and remaining do not add up to the order quantity");

  // an item is only emitted into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwrote an untaken item");

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the limit order book matcher
module tb_top;
  import lobm_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lobm_in_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lobm_out_t out_item;

  limit_order_book_matcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // book image
  logic        bk_valid [MAX_ORDERS];
  logic        bk_side [MAX_ORDERS];
  logic [63:0] bk_id [MAX_ORDERS];
  logic [31:0] bk_price [MAX_ORDERS];
  logic [31:0] bk_qty [MAX_ORDERS];
  logic [31:0] bk_arr [MAX_ORDERS];
  logic [31:0] arrival_ctr;

  lobm_in_t  order_queue [$];
  lobm_out_t book_results [$];
  int        fail_count = 0;
  bit        sender_hold = 1'b0;
  int        stall_burst = 0;
  logic [63:0] id_pool [$];

  // price-time ranking on one side
  function automatic bit outranks(int a, int b, logic s);
    logic [31:0] ka, kb;
    ka = bk_price[a] ^ SIGN_FLIP;
    kb = bk_price[b] ^ SIGN_FLIP;
    if (ka != kb) return (s == 1'b0) ? (ka > kb) : (ka < kb);
    return (arrival_ctr - bk_arr[a]) > (arrival_ctr - bk_arr[b]);
  endfunction

  function automatic int best_entry(logic s, bit by_id, logic [63:0] id);
    int b;
    b = -1;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      if (!bk_valid[i] || bk_side[i] != s) continue;
      if (by_id && bk_id[i] != id) continue;
      if (b < 0 || outranks(i, b, s)) b = i;
    end
    return b;
  endfunction

  function automatic bit cancel_by_id(logic [63:0] id);
    int i;
    i = best_entry(1'b0, 1'b1, id);
    if (i < 0) i = best_entry(1'b1, 1'b1, id);
    if (i < 0) return 1'b0;
    bk_valid[i] = 1'b0;
    return 1'b1;
  endfunction

  task automatic push_status(logic [2:0] st, logic [31:0] filled, logic [31:0] rem);
    lobm_out_t r;
    r = '0;
    r.result_kind = KIND_STATUS;
    r.status = st;
    r.filled_total = filled;
    r.qty_left = rem;
    r.last = 1'b1;
    book_results.insert(book_results.size(), r);
  endtask

  task automatic match_and_rest(lobm_in_t q, bit is_limit);
    logic [31:0] rem, filled, fill, kl, kb;
    int m;
    lobm_out_t r;
    rem = q.quantity;
    filled = '0;
    if (q.quantity == 0) begin
      push_status(ST_BADQTY, '0, '0);
      return;
    end
    while (rem > 0) begin
      m = best_entry(~q.side, 1'b0, '0);
      if (m < 0) break;
      if (is_limit) begin
        kl = q.px_limit ^ SIGN_FLIP;
        kb = bk_price[m] ^ SIGN_FLIP;
        if (q.side == 1'b0 ? kl < kb : kl > kb) break;
      end
      fill = (rem < bk_qty[m]) ? rem : bk_qty[m];
      r = '0;
      r.result_kind = KIND_TRADE;
      r.taker_id = q.req_id;
      r.maker_id = bk_id[m];
      r.trade_price = bk_price[m];
      r.fill_quantity = fill;
      book_results.insert(book_results.size(), r);
      bk_qty[m] -= fill;
      rem -= fill;
      filled += fill;
      if (bk_qty[m] == 0) bk_valid[m] = 1'b0;
    end
    if (rem == 0) begin
      push_status(ST_OK, filled, '0);
      return;
    end
    if (!is_limit) begin
      push_status(ST_MKTCXL, filled, rem);
      return;
    end
    for (int i = 0; i < MAX_ORDERS; i++) begin
      if (!bk_valid[i]) begin
        bk_valid[i] = 1'b1;
        bk_side[i] = q.side;
        bk_id[i] = q.req_id;
        bk_price[i] = q.px_limit;
        bk_qty[i] = rem;
        bk_arr[i] = arrival_ctr;
        arrival_ctr++;
        push_status(ST_OK, filled, rem);
        return;
      end
    end
    push_status(ST_FULL, filled, rem);
  endtask

  task automatic predict_request(lobm_in_t q);
    bit hit;
    case (q.mode)
      MODE_LIMIT:  match_and_rest(q, 1'b1);
      MODE_MARKET: match_and_rest(q, 1'b0);
      MODE_CANCEL: begin
        hit = cancel_by_id(q.req_id);
        push_status(hit ? ST_OK : ST_UNKNOWN, '0, '0);
      end
      default: begin
        void'(cancel_by_id(q.req_id));
        match_and_rest(q, 1'b1);
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // in_stall value at the last rising edge
  logic in_stall_seen = 1'b1;
  always @(posedge clk) in_stall_seen <= in_stall;

  // driver
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_seen) begin
        // item taken at the last rising edge
        predict_request(in_item);
        order_queue.delete(0);
        send_gap = gap_len();
      end
      if (!(in_valid && in_stall_seen)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (order_queue.size() > 0 && !sender_hold) begin
          in_valid <= 1'b1;
          in_item <= order_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  int recv_gap = 0;
  always @(posedge clk) begin
    lobm_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (book_results.size() == 0) begin
        report_mismatch("unexpected result", out_item.result_kind, 0);
      end else begin
        w = book_results[0];
        book_results.delete(0);
        if (out_item.result_kind != w.result_kind)
          report_mismatch("result_kind", out_item.result_kind, w.result_kind);
        if (out_item.taker_id != w.taker_id)
          report_mismatch("taker_id", out_item.taker_id, w.taker_id);
        if (out_item.maker_id != w.maker_id)
          report_mismatch("maker_id", out_item.maker_id, w.maker_id);
        if (out_item.trade_price != w.trade_price)
          report_mismatch("trade_price", out_item.trade_price, w.trade_price);
        if (out_item.fill_quantity != w.fill_quantity)
          report_mismatch("fill_quantity", out_item.fill_quantity, w.fill_quantity);
        if (out_item.status != w.status)
          report_mismatch("status", out_item.status, w.status);
        if (out_item.filled_total != w.filled_total)
          report_mismatch("filled_total", out_item.filled_total, w.filled_total);
        if (out_item.qty_left != w.qty_left)
          report_mismatch("qty_left", out_item.qty_left, w.qty_left);
        if (out_item.last != w.last)
          report_mismatch("last", out_item.last, w.last);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_burst > 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      recv_gap = gap_len();
      out_stall <= 1'b0;
    end
  end

  // request builders
  function automatic lobm_in_t mk(logic [1:0] md, logic [63:0] id, logic sd,
                                  logic [31:0] px, logic [31:0] qt);
    lobm_in_t q;
    q.mode = md;
    q.req_id = id;
    q.side = sd;
    q.px_limit = px;
    q.quantity = qt;
    return q;
  endfunction

  task automatic queue_request(lobm_in_t q);
    order_queue.insert(order_queue.size(), q);
  endtask

  function automatic logic [63:0] pick_id();
    if (id_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic lobm_in_t random_request();
    lobm_in_t q;
    int p;
    logic [31:0] px;
    p = $urandom_range(0, 99);
    px = 32'd1000 + $urandom_range(0, 12) - 6;
    if ($urandom_range(0, 19) == 0) px = $urandom;
    q = mk(MODE_LIMIT, pick_id(), 1'($urandom_range(0, 1)), px, $urandom_range(1, 40));
    if ($urandom_range(0, 29) == 0) q.quantity = $urandom;
    if ($urandom_range(0, 29) == 0) q.quantity = '0;
    if (p < 55) q.mode = MODE_LIMIT;
    else if (p < 68) q.mode = MODE_MARKET;
    else if (p < 85) q.mode = MODE_CANCEL;
    else q.mode = MODE_MODIFY;
    if (q.mode == MODE_LIMIT || q.mode == MODE_MODIFY)
      id_pool.insert(id_pool.size(), q.req_id);
    return q;
  endfunction

  task automatic wait_drained();
    while (order_queue.size() > 0 || in_valid || book_results.size() > 0)
      @(posedge clk);
  endtask

  // stimulus
  initial begin
    lobm_in_t q;
    for (int i = 0; i < MAX_ORDERS; i++) bk_valid[i] = 1'b0;
    arrival_ctr = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, each mode, special cases
    queue_request(mk(MODE_CANCEL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0, 5));
    queue_request(mk(MODE_LIMIT, 64'd1, 1'b0, 32'h8000_0000, 0));
    queue_request(mk(MODE_MARKET, 64'd2, 1'b1, 0, 0));
    queue_request(mk(MODE_MARKET, 64'd3, 1'b0, 0, 10));
    queue_request(mk(MODE_LIMIT, 64'd10, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    queue_request(mk(MODE_LIMIT, 64'd11, 1'b1, 32'd100, 7));
    queue_request(mk(MODE_LIMIT, 64'd12, 1'b1, 32'd100, 5));
    queue_request(mk(MODE_LIMIT, 64'd13, 1'b0, 32'h8000_0000, 9));
    queue_request(mk(MODE_LIMIT, 64'd20, 1'b0, 32'd100, 9));
    queue_request(mk(MODE_MARKET, 64'd21, 1'b0, 0, 8));
    queue_request(mk(MODE_LIMIT, 64'd12, 1'b0, 32'hFFFF_FFF0, 3));
    queue_request(mk(MODE_CANCEL, 64'd12, 1'b0, 0, 0));
    queue_request(mk(MODE_CANCEL, 64'd12, 1'b0, 0, 0));
    queue_request(mk(MODE_MODIFY, 64'd13, 1'b1, 32'h8000_0000, 4));
    queue_request(mk(MODE_MODIFY, 64'd77, 1'b0, 32'd5, 2));
    queue_request(mk(MODE_MODIFY, 64'd77, 1'b0, 32'd5, 0));
    queue_request(mk(MODE_MARKET, 64'hAAAA_5555_AAAA_5555, 1'b1, 0,
                     32'hFFFF_FFFF));
    wait_drained();

    // fill the book to provoke the full status, then sweep it
    for (int i = 0; i < MAX_ORDERS + 2; i++)
      queue_request(mk(MODE_LIMIT, 64'd500 + i, 1'b1, 32'd2000 + i % 3, 1));
    queue_request(mk(MODE_MARKET, 64'd600, 1'b0, 0, 32'hFFFF_FFFF));
    wait_drained();

    // receiver holds off while the sender keeps offering
    stall_burst = 300;
    for (int i = 0; i < 20; i++) begin
      q = random_request();
      queue_request(q);
    end
    wait_drained();

    // sender pauses until everything has arrived
    sender_hold = 1'b1;
    wait_drained();
    sender_hold = 1'b0;

    for (int i = 0; i < 150; i++) begin
      queue_request(random_request());
      if (id_pool.size() > 64) id_pool.delete(0);
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && book_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
